@@ hw/rtl/ils_pkg.sv @@
// Shared types and constants for the indexed list store.
// Holds the operation codes and the command and status bundles between
// the controller and the datapath. No dependencies.
package ils_pkg;

    // Operation codes carried by the operation field.
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_HEAD   = 3'd3;
    localparam logic [2:0] OP_TAIL   = 3'd4;

    // Value returned by a get whose index is absent.
    localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // latch the incoming command fields
        logic read_pos;     // read the store at the target position
        logic set_found;    // mark the get as found
        logic start_shift;  // prime the source pointer, pending flag and move counter
        logic set_acc;      // mark the list as changed
        logic shift_step;   // advance the shift by one entry
        logic write_value;  // write the new value at the target position
        logic count_inc;    // one entry more
        logic count_dec;    // one entry fewer
        logic out_load;     // load the result register
    } ils_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_get;
        logic is_ins;
        logic is_del;
        logic get_hit;
        logic ins_ok;
        logic del_ok;
        logic left_zero;
    } ils_status_t;

endpackage

@@ hw/rtl/ils_datapath.sv @@
// Datapath of the indexed list store: the entry memory, the entry count,
// the shift pointers and the result register. Depends on ils_pkg.
module ils_datapath
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         operation,
    input  logic signed [31:0] index,
    input  logic signed [31:0] value,
    input  ils_cmd_t           cmd,
    output ils_status_t        status,
    output logic signed [31:0] read_value,
    output logic               found,
    output logic               accepted,
    output logic [6:0]         list_length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Latched command fields.
    logic [2:0]    op_reg;
    logic [31:0]   idx_reg;
    logic [31:0]   val_reg;

    // Control state of the list and the shift.
    logic [CW-1:0] count_reg;
    logic [AW-1:0] src_reg;
    logic [AW-1:0] dest_reg;
    logic [CW-1:0] left_reg;
    logic          pend_reg;
    logic          found_reg;
    logic          acc_reg;

    // Memory and its registered read data.
    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;

    // Result register.
    logic [31:0]   read_value_reg;
    logic          found_reg_out;
    logic          accepted_reg;
    logic [6:0]    list_length_reg;

    logic          is_get;
    logic          is_ins;
    logic          is_del;
    logic          idx_lt_count;
    logic          idx_le_count;
    logic          full;
    logic [CW-1:0] pos;
    logic [CW-1:0] moves;
    logic          left_zero;
    logic          mem_ren;
    logic [AW-1:0] mem_raddr;
    logic          mem_wen;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    // Operation decode.
    always_comb
    begin
        is_get = 1'b0;
        is_ins = 1'b0;
        is_del = 1'b0;
        case (op_reg) inside
            OP_GET:                      is_get = 1'b1;
            OP_INSERT, OP_HEAD, OP_TAIL: is_ins = 1'b1;
            OP_DELETE:                   is_del = 1'b1;
            default:                     ;
        endcase
    end

    // Range checks of the index against the current length.
    assign idx_lt_count = !idx_reg[31] && (idx_reg < 32'(count_reg));
    assign idx_le_count = !idx_reg[31] && (idx_reg <= 32'(count_reg));
    assign full         = (count_reg == CW'(CAPACITY));
    assign left_zero    = (left_reg == '0);

    // Target position of the operation.
    always_comb
    begin
        case (op_reg)
            OP_HEAD: pos = '0;
            OP_TAIL: pos = count_reg;
            default: pos = idx_reg[CW-1:0];
        endcase
    end

    // Entries to move: those at and above the position for an insert,
    // those above it for a delete.
    assign moves = is_del ? (count_reg - pos - CW'(1)) : (count_reg - pos);

    // Status towards the controller.
    always_comb
    begin
        status.is_get    = is_get;
        status.is_ins    = is_ins;
        status.is_del    = is_del;
        status.get_hit   = idx_lt_count;
        status.ins_ok    = !full && ((op_reg != OP_INSERT) || idx_le_count);
        status.del_ok    = idx_lt_count;
        status.left_zero = left_zero;
    end

    // Memory port selection.
    assign mem_ren   = cmd.read_pos || (cmd.shift_step && !left_zero);
    assign mem_raddr = cmd.read_pos ? pos[AW-1:0] : src_reg;
    assign mem_wen   = cmd.write_value || (cmd.shift_step && pend_reg);
    assign mem_waddr = cmd.write_value ? pos[AW-1:0] : dest_reg;
    assign mem_wdata = cmd.write_value ? val_reg : rdata_reg;

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wen)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_ren)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Command fields and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            idx_reg <= index;
            val_reg <= value;
        end
        if (cmd.out_load)
        begin
            read_value_reg  <= found_reg ? rdata_reg : (is_get ? READ_MISS : '0);
            found_reg_out   <= found_reg;
            accepted_reg    <= acc_reg;
            list_length_reg <= 7'(count_reg);
        end
    end

    // Count, flags and shift pointers. Each shift step reads the next source entry
    // into the read register and writes the entry read by the step before it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            src_reg   <= '0;
            dest_reg  <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                acc_reg   <= 1'b0;
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.set_acc)
            begin
                acc_reg <= 1'b1;
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.start_shift)
            begin
                left_reg <= moves;
                pend_reg <= 1'b0;
                src_reg  <= is_del ? AW'(pos + CW'(1)) : AW'(count_reg - CW'(1));
            end
            if (cmd.shift_step)
            begin
                pend_reg <= !left_zero;
                if (!left_zero)
                begin
                    left_reg <= left_reg - CW'(1);
                    src_reg  <= is_del ? (src_reg + AW'(1)) : (src_reg - AW'(1));
                    dest_reg <= is_del ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                end
            end
        end
    end

    assign read_value  = read_value_reg;
    assign found       = found_reg_out;
    assign accepted    = accepted_reg;
    assign list_length = list_length_reg;

    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The count moves by at most one entry per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) ||
        (count_reg == $past(count_reg) + CW'(1)) ||
        (count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");

    // A transaction is either a found get or a change to the list, never both.
    assert property (@(posedge clk) disable iff (!rst_n) !(found_reg && acc_reg))
        else $error("found and changed flags both set");

endmodule

@@ hw/rtl/ils_ctrl.sv @@
// Controller of the indexed list store: sequences evaluation, the shift
// pass, the value write and the result transaction. Depends on ils_pkg.
module ils_ctrl
    import ils_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  ils_status_t status,
    output ils_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_FILL,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_RESP;
                if (status.is_get && status.get_hit)
                begin
                    cmd.read_pos  = 1'b1;
                    cmd.set_found = 1'b1;
                end
                else if ((status.is_ins && status.ins_ok) ||
                         (status.is_del && status.del_ok))
                begin
                    cmd.start_shift = 1'b1;
                    cmd.set_acc     = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (status.left_zero)
                begin
                    if (status.is_ins)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = S_RESP;
                    end
                end
            end
            S_FILL:
            begin
                cmd.write_value = 1'b1;
                cmd.count_inc   = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // An accepted command is evaluated in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == S_EVAL))
        else $error("accepted command not evaluated");

    // A result only appears straight after the response state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response state");

    // A finished shift leads to the value write or the response.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && status.left_zero) |=>
        (state_reg == S_FILL || state_reg == S_RESP))
        else $error("shift pass did not finish");

endmodule

@@ hw/rtl/indexed_list_store_core.sv @@
// Indexed list store: an ordered list of signed 32-bit values with get,
// insert and delete by position. One command is in work at a time.
// A get or a rejected command goes from evaluation straight to the response
// state; an insert or delete first runs the shift pass, one entry moved per
// step, and an insert then writes the new value before the response.
// Reset empties the list; the entry memory itself is not cleared.
module indexed_list_store_core
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         operation,
    input  logic signed [31:0] index,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] read_value,
    output logic               found,
    output logic               accepted,
    output logic [6:0]         list_length
);

    ils_cmd_t    cmd;
    ils_status_t status;

    // Sequencing of each transaction.
    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage, shift pointers and result register.
    ils_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .index       (index),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .read_value  (read_value),
        .found       (found),
        .accepted    (accepted),
        .list_length (list_length)
    );

endmodule

@@ tb/tb_indexed_list_store_core.sv @@
// Self-checking testbench for indexed_list_store_core: a short table of edge-case commands,
// then phased random traffic, checked against the table or a shadow copy of the list.
// Depends on ils_pkg for the operation codes and on the core itself.
`timescale 1ns / 1ps

module tb_indexed_list_store_core;
    import ils_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int N_DIRECTED   = 23;
    localparam int RANDOM_ITEMS = 1150;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;

    // Codes the core must treat as no-operation.
    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic [2:0] UNUSED_OPS [3] = '{OP_UNUSED_5, OP_UNUSED_6, OP_UNUSED_7};

    localparam logic [31:0] EDGE_WORDS [4] =
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               found;
        logic               accepted;
        logic [6:0]         list_length;
    } status_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] idx;
        logic signed [31:0] val;
        logic               typed;
        status_t            want;
    } vector_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic [2:0]         operation = OP_GET;
    logic signed [31:0] index = '0;
    logic signed [31:0] value = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic signed [31:0] read_value;
    logic               found;
    logic               accepted;
    logic [6:0]         list_length;

    // Shadow copy of the list and the statuses still owed by the core.
    logic signed [31:0] shadow_entries [CAPACITY];
    int                 shadow_count = 0;
    status_t            awaited_status [$];
    int                 err_count = 0;

    vector_t            directed_vectors [N_DIRECTED];

    // Receiver stall pattern state.
    int                 stall_style = 0;
    int                 stall_phase_left = 0;
    int                 stall_run = 0;

    indexed_list_store_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .index       (index),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_value  (read_value),
        .found       (found),
        .accepted    (accepted),
        .list_length (list_length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the shadow list and return the status it should give.
    function automatic status_t apply_list_op(logic [2:0] op, logic signed [31:0] idx,
                                              logic signed [31:0] val);
        status_t st;
        bit      do_insert;
        int      pos;
        int      k;
        st        = '0;
        do_insert = 1'b0;
        pos       = 0;
        case (op)
            OP_GET:
            begin
                if (idx >= 0 && idx < shadow_count)
                begin
                    st.read_value = shadow_entries[idx];
                    st.found      = 1'b1;
                end
                else
                begin
                    st.read_value = READ_MISS;
                end
            end
            OP_INSERT:
            begin
                if (idx >= 0 && idx <= shadow_count)
                begin
                    do_insert = 1'b1;
                    pos       = idx;
                end
            end
            OP_DELETE:
            begin
                if (idx >= 0 && idx < shadow_count)
                begin
                    for (k = idx; k + 1 < shadow_count; k++)
                        shadow_entries[k] = shadow_entries[k + 1];
                    shadow_count--;
                    st.accepted = 1'b1;
                end
            end
            OP_HEAD:
            begin
                do_insert = 1'b1;
                pos       = 0;
            end
            OP_TAIL:
            begin
                do_insert = 1'b1;
                pos       = shadow_count;
            end
            default:
            begin
            end
        endcase
        // Every insert kind is dropped once the store is full.
        if (do_insert && shadow_count < CAPACITY)
        begin
            for (k = shadow_count; k > pos; k--)
                shadow_entries[k] = shadow_entries[k - 1];
            shadow_entries[pos] = val;
            shadow_count++;
            st.accepted = 1'b1;
        end
        st.list_length = shadow_count[6:0];
        return st;
    endfunction

    // Choose an operation, weighted by the current traffic mix.
    function automatic logic [2:0] pick_op(mix_t mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return UNUSED_OPS[$urandom_range(0, 2)];
        case (mix)
            MIX_GROW:
                return (roll < 20) ? OP_GET : (roll < 30) ? OP_DELETE :
                       (roll < 55) ? OP_INSERT : (roll < 75) ? OP_HEAD : OP_TAIL;
            MIX_SHRINK:
                return (roll < 25) ? OP_GET : (roll < 75) ? OP_DELETE :
                       (roll < 85) ? OP_INSERT : (roll < 92) ? OP_HEAD : OP_TAIL;
            default:
                return (roll < 30) ? OP_GET : (roll < 55) ? OP_DELETE :
                       (roll < 75) ? OP_INSERT : (roll < 87) ? OP_HEAD : OP_TAIL;
        endcase
    endfunction

    // Mostly positions in or just past the list, with some far out of range.
    function automatic logic signed [31:0] pick_index();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, shadow_count);
        else if (roll < 80)
            return shadow_count + int'($urandom_range(1, 3));
        else if (roll < 88)
            return -int'($urandom_range(1, 3));
        else if (roll < 94)
            return EDGE_WORDS[$urandom_range(2, 3)];
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return EDGE_WORDS[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // Present one command and hold it until the core takes the transaction.
    task automatic send_command(input logic [2:0] op, input logic signed [31:0] idx,
                                input logic signed [31:0] val, input logic typed,
                                input status_t want);
        status_t predicted;
        cmd_valid <= 1'b1;
        operation <= op;
        index     <= idx;
        value     <= val;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = apply_list_op(op, idx, val);
        awaited_status.push_back(typed ? want : predicted);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold the command side off until every owed status has come back.
    task automatic drain_replies();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaited_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        err_count++;
    endtask

    // Receiver: stalls on its own changing pattern and checks each transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (stall_phase_left == 0)
            begin
                stall_style      <= $urandom_range(0, 3);
                stall_phase_left <= $urandom_range(50, 400);
            end
            else
            begin
                stall_phase_left <= stall_phase_left - 1;
            end
            case (stall_style)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 99) < 40);
                2: rsp_stall <= ~rsp_stall;
                default:
                begin
                    if (stall_run == 0)
                    begin
                        rsp_stall <= ~rsp_stall;
                        stall_run <= $urandom_range(1, 30);
                    end
                    else
                    begin
                        stall_run <= stall_run - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_status.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h/%b/%b/%0d", $time,
                         read_value, found, accepted, list_length);
                err_count++;
            end
            else
            begin
                want = awaited_status.pop_front();
                if (read_value !== want.read_value)
                    flag_mismatch("read_value", want.read_value, read_value);
                if (found !== want.found)
                    flag_mismatch("found", 32'(want.found), 32'(found));
                if (accepted !== want.accepted)
                    flag_mismatch("accepted", 32'(want.accepted), 32'(accepted));
                if (list_length !== want.list_length)
                    flag_mismatch("list_length", 32'(want.list_length), 32'(list_length));
            end
        end
    end

    // Main stimulus sequence.
    initial
    begin
        int      items_sent;
        int      seg_len;
        int      burst_left;
        int      n;
        bit      first_seg;
        mix_t    mix;
        vector_t row;

        // Rows with typed=0 are checked against the shadow list only.
        directed_vectors = '{
            // Empty list: every lookup misses, nothing can be removed, out-of-range inserts are refused.
            '{OP_GET,      32'sd0,           32'sd0,        1'b1, '{READ_MISS, 1'b0, 1'b0, 7'd0}},
            '{OP_DELETE,   32'sd0,           32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}},
            '{OP_INSERT,   32'sd1,           32'sd7,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}},
            '{OP_INSERT,   -32'sd1,          32'sd7,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd0}},
            // Build up the list with every insert kind and extreme values.
            '{OP_INSERT,   32'sd0,           32'h7FFF_FFFF, 1'b1, '{32'sd0, 1'b0, 1'b1, 7'd1}},
            '{OP_HEAD,     32'sd9,           32'h8000_0000, 1'b1, '{32'sd0, 1'b0, 1'b1, 7'd2}},
            '{OP_TAIL,     -32'sd5,          32'hFFFF_FFFF, 1'b1, '{32'sd0, 1'b0, 1'b1, 7'd3}},
            '{OP_INSERT,   32'sd3,           32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b1, 7'd4}},
            '{OP_INSERT,   32'sd2,           32'h5A5A_5A5A, 1'b0, '0},
            // Lookups in range, at the end and far outside it.
            '{OP_GET,      32'sd0,           32'sd0,        1'b1, '{32'h8000_0000, 1'b1, 1'b0, 7'd5}},
            '{OP_GET,      32'sd4,           32'sd0,        1'b0, '0},
            '{OP_GET,      32'h8000_0000,    32'sd0,        1'b1, '{READ_MISS, 1'b0, 1'b0, 7'd5}},
            '{OP_GET,      32'h7FFF_FFFF,    32'sd0,        1'b1, '{READ_MISS, 1'b0, 1'b0, 7'd5}},
            '{OP_GET,      32'sd5,           32'sd0,        1'b1, '{READ_MISS, 1'b0, 1'b0, 7'd5}},
            // Deletes at invalid positions leave the list alone, then two valid deletes shrink it.
            '{OP_DELETE,   -32'sd1,          32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd5}},
            '{OP_DELETE,   32'sd5,           32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd5}},
            '{OP_DELETE,   32'h7FFF_FFFF,    32'sd0,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd5}},
            '{OP_DELETE,   32'sd2,           32'sd0,        1'b0, '0},
            '{OP_DELETE,   32'sd0,           32'sd0,        1'b0, '0},
            // Unused operation codes change nothing; a final get reads the list.
            '{OP_UNUSED_5, 32'sd0,           32'sd1,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}},
            '{OP_UNUSED_6, 32'sd1,           32'sd2,        1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}},
            '{OP_UNUSED_7, 32'hFFFF_FFFF,    32'hFFFF_FFFF, 1'b1, '{32'sd0, 1'b0, 1'b0, 7'd3}},
            '{OP_GET,      32'sd1,           32'sd0,        1'b0, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_DIRECTED; n++)
        begin
            row = directed_vectors[n];
            send_command(row.op, row.idx, row.val, row.typed, row.want);
        end

        // Random traffic in segments of one mix each; the first one uses the growing mix,
        // and some segments start only once the core has gone quiet.
        items_sent = 0;
        burst_left = 0;
        first_seg  = 1'b1;
        while (items_sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(60, 160);
            mix     = first_seg ? MIX_GROW : mix_t'($urandom_range(0, 2));
            if (first_seg || $urandom_range(0, 2) == 0)
                drain_replies();
            first_seg = 1'b0;
            for (n = 0; n < seg_len && items_sent < RANDOM_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    idle_for($urandom_range(1, 10));
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 20);
                end
                burst_left--;
                send_command(pick_op(mix), pick_index(), pick_value(), 1'b0, '0);
                items_sent++;
            end
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a core that stops answering.
    initial
    begin
        #15_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, awaited_status.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ils_pkg.sv
hw/rtl/ils_datapath.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store_core.sv
tb/tb_indexed_list_store_core.sv
